### design/wrdtc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wrdtc_pkg;

	// Timer and configuration widths
	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CFG_LEN_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic                 CTRL_SEL_RST = 1'b1;
	localparam logic [CFG_LEN_W-1:0] RUN_TICKS_RST = 16'd81;
	localparam logic [CFG_LEN_W-1:0] PAUSE_TICKS_RST = 16'd24;

	// Relay drive patterns
	localparam logic [2:0] RELAYS_OFF = 3'd0;
	localparam logic [2:0] RELAYS_UP = 3'd6;
	localparam logic [2:0] RELAYS_DOWN = 3'd3;

	// Item kinds
	localparam logic KIND_TICK = 1'b0;

	// Motor modes
	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_UP = 3'd1,
		MODE_DOWN = 3'd2,
		MODE_PAUSE_UP = 3'd3,
		MODE_PAUSE_DOWN = 3'd4,
		MODE_PAUSE_IDLE = 3'd5
	} mode_t;

	// Received commands
	typedef enum logic [1:0] {
		CMD_STOP_LO = 2'd0,
		CMD_DOWN = 2'd1,
		CMD_UP = 2'd2,
		CMD_STOP_HI = 2'd3
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CTRL_SEL = 2'd0,
		REG_RUN_TICKS = 2'd1,
		REG_PAUSE_TICKS = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

### design/winch_reversal_dead_time_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Winch reversal dead-time controller.
// Input channel (in_valid / in_stall) carries one item per transaction: kind 0 is
// a time tick, kind 1 a received command byte in frame_byte. Every item yields
// exactly one result on the output channel (out_valid / out_stall): the relay
// mask and motor mode after that item.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are always
// taken; index 0 selects the command bit pair, 1 sets run ticks, 2 pause ticks.
// An accepted item enters the input register; its result is then loaded into
// the state/result register, from which it is presented. Throughput is one
// item per cycle while the receiver does not stall: the mode and countdown
// update in a single pass of logic between the two registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, then in_stall rises until the result is taken.
// Reset: idle mode, relays off, timer expired, both stages empty, registers
// back to controller select 1, run 81 ticks, pause 24 ticks.
module winch_reversal_dead_time_controller_core #(
	parameter int TIMER_WIDTH = wrdtc_pkg::TIMER_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              kind,
	input  wire  [7:0]                       frame_byte,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [2:0]                       relay_mask,
	output logic [2:0]                       motor_mode,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [wrdtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [wrdtc_pkg::CFG_DATA_W-1:0] cfg_data
);

	import wrdtc_pkg::*;

	logic                   ctrl_sel_q;
	logic [CFG_LEN_W-1:0]   run_ticks_q;
	logic [CFG_LEN_W-1:0]   pause_ticks_q;

	logic                   vld_s1;
	logic                   kind_s1;
	logic [7:0]             byte_s1;

	logic                   out_vld_q;
	mode_t                  mode_q;
	logic [TIMER_WIDTH-1:0] ticks_q;
	logic [2:0]             relay_q;

	mode_t                  mode_d;
	logic [TIMER_WIDTH-1:0] ticks_d;
	logic [2:0]             relay_d;

	logic                   adv_s2;
	logic                   adv_s1;
	logic [TIMER_WIDTH-1:0] run_len;
	logic [TIMER_WIDTH-1:0] pause_len;
	logic [TIMER_WIDTH-1:0] ticks_dec;
	logic                   expired;
	cmd_t                   cmd;
	logic                   up;
	mode_t                  same_run;
	mode_t                  same_pause;

	// Flow control: result stage loads when empty or taken, input stage follows
	assign adv_s2 = !out_vld_q || !out_stall;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign relay_mask = relay_q;
	assign motor_mode = mode_q;

	// Saturate loaded lengths to the timer width
	generate
		if (TIMER_WIDTH >= CFG_LEN_W) begin : g_len_wide
			assign run_len = TIMER_WIDTH'(run_ticks_q);
			assign pause_len = TIMER_WIDTH'(pause_ticks_q);
		end else begin : g_len_narrow
			assign run_len = (run_ticks_q[CFG_LEN_W-1:TIMER_WIDTH] != '0) ?
				'1 : run_ticks_q[TIMER_WIDTH-1:0];
			assign pause_len = (pause_ticks_q[CFG_LEN_W-1:TIMER_WIDTH] != '0) ?
				'1 : pause_ticks_q[TIMER_WIDTH-1:0];
		end
	endgenerate

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_sel_q <= CTRL_SEL_RST;
			run_ticks_q <= RUN_TICKS_RST;
			pause_ticks_q <= PAUSE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CTRL_SEL: ctrl_sel_q <= cfg_data[0];
				REG_RUN_TICKS: run_ticks_q <= cfg_data[CFG_LEN_W-1:0];
				REG_PAUSE_TICKS: pause_ticks_q <= cfg_data[CFG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			kind_s1 <= kind;
			byte_s1 <= frame_byte;
		end
	end

	// Decode command and countdown
	assign cmd = ctrl_sel_q ? cmd_t'(byte_s1[6:5]) : cmd_t'(byte_s1[2:1]);
	assign up = (cmd == CMD_UP);
	assign same_run = up ? MODE_UP : MODE_DOWN;
	assign same_pause = up ? MODE_PAUSE_UP : MODE_PAUSE_DOWN;
	assign ticks_dec = ticks_q - TIMER_WIDTH'(ticks_q != '0);
	assign expired = (ticks_dec == '0);

	// Next mode, relays and timer for the item in the input register
	always_comb begin
		mode_d = mode_q;
		relay_d = relay_q;
		ticks_d = ticks_q;
		if (kind_s1 == KIND_TICK) begin
			ticks_d = ticks_dec;
			case (mode_q)
				MODE_UP, MODE_DOWN: begin
					if (expired) begin
						mode_d = MODE_PAUSE_IDLE;
						relay_d = RELAYS_OFF;
						ticks_d = pause_len;
					end
				end
				MODE_PAUSE_UP: begin
					if (expired) begin
						mode_d = MODE_UP;
						relay_d = RELAYS_UP;
						ticks_d = run_len;
					end
				end
				MODE_PAUSE_DOWN: begin
					if (expired) begin
						mode_d = MODE_DOWN;
						relay_d = RELAYS_DOWN;
						ticks_d = run_len;
					end
				end
				MODE_PAUSE_IDLE: begin
					if (expired) begin
						mode_d = MODE_IDLE;
						relay_d = RELAYS_OFF;
						ticks_d = '0;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					relay_d = RELAYS_OFF;
					ticks_d = '0;
				end
			endcase
		end else if (cmd == CMD_UP || cmd == CMD_DOWN) begin
			if (mode_q == MODE_IDLE) begin
				mode_d = same_run;
				relay_d = up ? RELAYS_UP : RELAYS_DOWN;
				ticks_d = run_len;
			end else if (mode_q == same_run) begin
				// retrigger the run
				ticks_d = run_len;
			end else if (mode_q == same_pause) begin
				// keep waiting out the dead time
			end else if (mode_q <= MODE_PAUSE_IDLE) begin
				mode_d = same_pause;
				relay_d = RELAYS_OFF;
				ticks_d = pause_len;
			end
		end else begin
			mode_d = MODE_IDLE;
			relay_d = RELAYS_OFF;
			ticks_d = '0;
		end
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			mode_q <= MODE_IDLE;
			relay_q <= RELAYS_OFF;
			ticks_q <= '0;
		end else if (adv_s2) begin
			out_vld_q <= vld_s1;
			if (vld_s1) begin
				mode_q <= mode_d;
				relay_q <= relay_d;
				ticks_q <= ticks_d;
			end
		end
	end

	// Relays agree with the mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_UP && relay_q == RELAYS_UP) ||
		(mode_q == MODE_DOWN && relay_q == RELAYS_DOWN) ||
		(mode_q != MODE_UP && mode_q != MODE_DOWN && relay_q == RELAYS_OFF))
		else $error("relay mask does not match motor mode");

	// Idle always has an expired timer
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> ticks_q == '0)
		else $error("timer running in idle");

	// A held input item stays put while the result stage is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s2 |=> vld_s1 && $stable(kind_s1) && $stable(byte_s1))
		else $error("input register lost an item under stall");

endmodule

`default_nettype wire
